>>> rtl/mptc_pkg.sv
`timescale 1ns / 1ps
// Package for the media player transport control block.
// Field widths, event/action/mode codes and the types shared by the RTL modules.
package mptc_pkg;

	// fixed field widths
	localparam int CNT_W   = 11;
	localparam int FUNC_W  = 4;
	localparam int FAULT_W = 4;
	localparam int ACT_W   = 3;
	localparam int MODE_W  = 3;
	localparam int TRK_W   = 10;
	localparam int ERR_W   = 4;
	localparam int VOLO_W  = 5;
	localparam int GAIN_W  = 16;

	localparam int GAIN_ONE = 32'h8000;

	// parameter defaults
	localparam int MAX_TRACKS_DEF     = 1024;
	localparam int VOLUME_STEPS_DEF   = 16;
	localparam int DEFAULT_VOLUME_DEF = 12;

	// stream payload widths
	localparam int IN_FIELDS_W  = FUNC_W + 1 + FAULT_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = ACT_W + MODE_W + TRK_W + ERR_W + 1 + VOLO_W + GAIN_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [FUNC_W-1:0] {
		FN_BEGIN       = 4'd0,
		FN_LOADED      = 4'd1,
		FN_PREFILLED   = 4'd2,
		FN_PREV        = 4'd3,
		FN_NEXT        = 4'd4,
		FN_PLAY_PAUSE  = 4'd5,
		FN_VOL_DOWN    = 4'd6,
		FN_VOL_UP      = 4'd7,
		FN_NATURAL_END = 4'd8,
		FN_FAIL        = 4'd9
	} func_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE   = 3'd0,
		ACT_LOAD   = 3'd1,
		ACT_START  = 3'd2,
		ACT_PAUSE  = 3'd3,
		ACT_RESUME = 3'd4,
		ACT_VOLUME = 3'd5,
		ACT_STOP   = 3'd6
	} action_t;

	// player mode, one-hot
	typedef enum logic [6:0] {
		MODE_EMPTY      = 7'b0000001,
		MODE_STOPPED    = 7'b0000010,
		MODE_LOADING    = 7'b0000100,
		MODE_PREFILLING = 7'b0001000,
		MODE_PLAYING    = 7'b0010000,
		MODE_PAUSED     = 7'b0100000,
		MODE_ERROR      = 7'b1000000
	} mode_t;

	// mode codes as seen on the result stream
	localparam logic [MODE_W-1:0] MC_EMPTY      = 3'd0;
	localparam logic [MODE_W-1:0] MC_STOPPED    = 3'd1;
	localparam logic [MODE_W-1:0] MC_LOADING    = 3'd2;
	localparam logic [MODE_W-1:0] MC_PREFILLING = 3'd3;
	localparam logic [MODE_W-1:0] MC_PLAYING    = 3'd4;
	localparam logic [MODE_W-1:0] MC_PAUSED     = 3'd5;
	localparam logic [MODE_W-1:0] MC_ERROR      = 3'd6;

	typedef struct packed {
		logic [FAULT_W-1:0] fault_code;
		logic               loop_request;
		logic [FUNC_W-1:0]  func;
	} evt_t;

	typedef struct packed {
		logic up;
		logic down;
	} vol_cmd_t;

	typedef struct packed {
		logic at_min;
		logic at_max;
	} vol_stat_t;

	function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
		logic [MODE_W-1:0] c;
		unique case (m)
			MODE_EMPTY:      c = MC_EMPTY;
			MODE_STOPPED:    c = MC_STOPPED;
			MODE_LOADING:    c = MC_LOADING;
			MODE_PREFILLING: c = MC_PREFILLING;
			MODE_PLAYING:    c = MC_PLAYING;
			MODE_PAUSED:     c = MC_PAUSED;
			MODE_ERROR:      c = MC_ERROR;
			default:         c = MC_EMPTY;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/mptc_vol.sv
`timescale 1ns / 1ps
// Volume step register and Q15 gain tracker.
// Gain is kept as quotient and remainder of step*0x8000/VOLUME_STEPS; uses mptc_pkg.
module mptc_vol
	import mptc_pkg::*;
#(
	parameter int VOLUME_STEPS   = VOLUME_STEPS_DEF,
	parameter int DEFAULT_VOLUME = DEFAULT_VOLUME_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              reinit,
	input  vol_cmd_t          cmd,
	output vol_stat_t         stat,
	output logic [VOLO_W-1:0] volume_level,
	output logic [GAIN_W-1:0] volume_gain
);

	localparam int VOL_MAX = (DEFAULT_VOLUME > VOLUME_STEPS) ? DEFAULT_VOLUME : VOLUME_STEPS;
	localparam int VW      = $clog2(VOL_MAX + 1);
	localparam int RW      = (VOLUME_STEPS > 1) ? $clog2(VOLUME_STEPS) : 1;
	localparam int SW      = RW + 1;
	localparam int Q0      = GAIN_ONE / VOLUME_STEPS;
	localparam int R0      = GAIN_ONE % VOLUME_STEPS;
	localparam int MIN_DEF = (DEFAULT_VOLUME > VOLUME_STEPS) ? VOLUME_STEPS : DEFAULT_VOLUME;
	localparam int G_DEF   = (MIN_DEF * GAIN_ONE) / VOLUME_STEPS;
	localparam int R_DEF   = (MIN_DEF * GAIN_ONE) % VOLUME_STEPS;

	logic [VW-1:0]     vol_q;
	logic [GAIN_W-1:0] gain_q;
	logic [RW-1:0]     rem_q;
	logic [SW-1:0]     rem_up;
	logic [SW-1:0]     rem_dn;
	logic              up_wrap;
	logic              dn_borrow;
	logic              gain_dn_en;

	assign stat.at_min = (vol_q == '0);
	assign stat.at_max = (32'(vol_q) >= 32'(VOLUME_STEPS));

	// step up: remainder grows by R0, carries once at most
	assign rem_up  = SW'(rem_q) + SW'(R0);
	assign up_wrap = (32'(rem_up) >= 32'(VOLUME_STEPS));
	// step down: borrow one from the quotient when the remainder underflows
	assign dn_borrow = (32'(rem_q) < 32'(R0));
	assign rem_dn    = dn_borrow ? (SW'(rem_q) + SW'(VOLUME_STEPS) - SW'(R0))
	                             : (SW'(rem_q) - SW'(R0));
	// above the step count the gain is pinned at full scale
	assign gain_dn_en = (32'(vol_q) <= 32'(VOLUME_STEPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q  <= VW'(DEFAULT_VOLUME);
			gain_q <= GAIN_W'(G_DEF);
			rem_q  <= RW'(R_DEF);
		end else if (reinit) begin
			vol_q  <= VW'(DEFAULT_VOLUME);
			gain_q <= GAIN_W'(G_DEF);
			rem_q  <= RW'(R_DEF);
		end else if (cmd.up) begin
			vol_q <= vol_q + VW'(1);
			if (up_wrap) begin
				gain_q <= gain_q + GAIN_W'(Q0 + 1);
				rem_q  <= RW'(rem_up - SW'(VOLUME_STEPS));
			end else begin
				gain_q <= gain_q + GAIN_W'(Q0);
				rem_q  <= RW'(rem_up);
			end
		end else if (cmd.down) begin
			vol_q <= vol_q - VW'(1);
			if (gain_dn_en) begin
				gain_q <= gain_q - (dn_borrow ? GAIN_W'(Q0 + 1) : GAIN_W'(Q0));
				rem_q  <= RW'(rem_dn);
			end
		end
	end

	assign volume_level = VOLO_W'(vol_q);
	assign volume_gain  = gain_q;

`ifndef SYNTHESIS
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(gain_q) <= GAIN_ONE)
		else $error("volume gain above full scale");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rem_q) < 32'(VOLUME_STEPS) || VOLUME_STEPS == 1)
		else $error("gain remainder out of range");
	a_full_at_top: assert property (@(posedge clk) disable iff (!arst_n)
		stat.at_max |-> (32'(gain_q) == GAIN_ONE))
		else $error("gain not full scale at top step");
	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.up && cmd.down))
		else $error("volume up and down in the same cycle");
`endif

endmodule

>>> rtl/mptc_ctrl.sv
`timescale 1ns / 1ps
// Transport state: mode, selected track, error code, loop flag and track count.
// Decodes one event per advance and issues volume commands; uses mptc_pkg.
module mptc_ctrl
	import mptc_pkg::*;
#(
	parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_count,
	input  logic              adv,
	input  evt_t              evt,
	input  vol_stat_t         vstat,
	output vol_cmd_t          vcmd,
	output action_t           action_d,
	output logic [MODE_W-1:0] player_mode,
	output logic [TRK_W-1:0]  track_index,
	output logic [ERR_W-1:0]  error_status,
	output logic              loop_active
);

	mode_t              mode_q, mode_d;
	logic [CNT_W-1:0]   tc_q;
	logic [CNT_W-1:0]   sel_q, sel_d;
	logic [ERR_W-1:0]   err_q, err_d;
	logic               loop_q, loop_d;
	logic [CNT_W-1:0]   tc_new;
	logic [CNT_W:0]     sel_inc;
	logic [CNT_W-1:0]   sel_fwd;
	logic [CNT_W-1:0]   sel_back;
	logic               have_tracks;
	logic               begin_ok;
	logic               vol_up_d;
	logic               vol_dn_d;

	assign tc_new = (32'(cfg_count) > 32'(MAX_TRACKS)) ? CNT_W'(MAX_TRACKS) : cfg_count;

	assign have_tracks = (tc_q != '0);
	assign begin_ok    = have_tracks && (mode_q == MODE_STOPPED || mode_q == MODE_ERROR);
	assign sel_inc     = {1'b0, sel_q} + (CNT_W+1)'(1);
	assign sel_fwd     = (sel_inc >= {1'b0, tc_q}) ? '0 : sel_inc[CNT_W-1:0];
	assign sel_back    = (sel_q == '0 || sel_q >= tc_q) ? (tc_q - CNT_W'(1))
	                                                    : (sel_q - CNT_W'(1));

	always_comb begin
		mode_d   = mode_q;
		sel_d    = sel_q;
		err_d    = err_q;
		loop_d   = loop_q;
		action_d = ACT_NONE;
		vol_up_d = 1'b0;
		vol_dn_d = 1'b0;
		unique case (func_t'(evt.func)) inside
			FN_BEGIN: begin
				if (begin_ok) begin
					mode_d   = MODE_LOADING;
					err_d    = '0;
					loop_d   = 1'b0;
					action_d = ACT_LOAD;
				end
			end
			FN_LOADED: begin
				if (mode_q == MODE_LOADING) begin
					mode_d = MODE_PREFILLING;
					loop_d = evt.loop_request;
				end
			end
			FN_PREFILLED: begin
				if (mode_q == MODE_PREFILLING) begin
					mode_d   = MODE_PLAYING;
					action_d = ACT_START;
				end
			end
			FN_PREV, FN_NEXT: begin
				if (have_tracks) begin
					sel_d    = (func_t'(evt.func) == FN_NEXT) ? sel_fwd : sel_back;
					mode_d   = MODE_LOADING;
					err_d    = '0;
					loop_d   = 1'b0;
					action_d = ACT_LOAD;
				end
			end
			FN_PLAY_PAUSE: begin
				if (mode_q == MODE_PLAYING) begin
					mode_d   = MODE_PAUSED;
					action_d = ACT_PAUSE;
				end else if (mode_q == MODE_PAUSED) begin
					mode_d   = MODE_PLAYING;
					action_d = ACT_RESUME;
				end else if (begin_ok) begin
					mode_d   = MODE_LOADING;
					err_d    = '0;
					loop_d   = 1'b0;
					action_d = ACT_LOAD;
				end
			end
			FN_VOL_DOWN: begin
				if (!vstat.at_min) begin
					vol_dn_d = 1'b1;
					action_d = ACT_VOLUME;
				end
			end
			FN_VOL_UP: begin
				if (!vstat.at_max) begin
					vol_up_d = 1'b1;
					action_d = ACT_VOLUME;
				end
			end
			FN_NATURAL_END: begin
				if (mode_q == MODE_PLAYING && !loop_q && have_tracks) begin
					sel_d    = sel_fwd;
					mode_d   = MODE_LOADING;
					err_d    = '0;
					loop_d   = 1'b0;
					action_d = ACT_LOAD;
				end
			end
			FN_FAIL: begin
				if (evt.fault_code != '0) begin
					mode_d   = MODE_ERROR;
					err_d    = evt.fault_code;
					loop_d   = 1'b0;
					action_d = ACT_STOP;
				end
			end
			default: begin
				// unused event codes leave everything as is
			end
		endcase
	end

	assign vcmd.up   = adv && vol_up_d;
	assign vcmd.down = adv && vol_dn_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EMPTY;
			tc_q   <= '0;
			sel_q  <= '0;
			err_q  <= '0;
			loop_q <= 1'b0;
		end else if (cfg_we) begin
			tc_q   <= tc_new;
			mode_q <= (tc_new == '0) ? MODE_EMPTY : MODE_STOPPED;
			sel_q  <= '0;
			err_q  <= '0;
			loop_q <= 1'b0;
		end else if (adv) begin
			mode_q <= mode_d;
			sel_q  <= sel_d;
			err_q  <= err_d;
			loop_q <= loop_d;
		end
	end

	assign player_mode  = mode_code(mode_q);
	assign track_index  = sel_q[TRK_W-1:0];
	assign error_status = err_q;
	assign loop_active  = loop_q;

`ifndef SYNTHESIS
	a_err_iff_error_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != '0) == (mode_q == MODE_ERROR))
		else $error("error code and error mode disagree");
	a_loop_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		loop_q |-> (mode_q == MODE_PREFILLING || mode_q == MODE_PLAYING ||
		            mode_q == MODE_PAUSED))
		else $error("loop flag set outside a loaded track");
	a_sel_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		have_tracks |-> (sel_q < tc_q))
		else $error("selected track beyond track count");
`endif

endmodule

>>> rtl/media_player_transport_control.sv
`timescale 1ns / 1ps
// Media player transport control, top level: input and result registers around
// the transport state (mptc_ctrl) and the volume/gain tracker (mptc_vol); uses mptc_pkg.
//
// Usage:
//  - cfg_valid/cfg_ready/cfg_data writes the track count (11 bits, saturated at
//    MAX_TRACKS) and reinitializes the player; cfg_ready is always high. Write it
//    only while no item is in flight.
//  - s_tvalid/s_tready/s_tdata carries one event item; m_tvalid/m_tready/m_tdata
//    carries exactly one result item per event, in order.
//  - An accepted item lands in the input register; on an advance its event is
//    decoded, the state registers update and the result register loads. The
//    result is registered and can be taken while m_tvalid is high.
//  - Throughput is one item per cycle: the input register advances whenever the
//    result register is empty or being drained in the same cycle.
//  - If m_tready is held low, the result holds, the input register fills, and
//    then s_tready drops until the result is taken. Nothing is dropped.
//  - Reset (arst_n low) clears both registers, sets the track count to zero,
//    the mode to empty, track, error and loop to zero, and the volume to
//    DEFAULT_VOLUME.
module media_player_transport_control
	import mptc_pkg::*;
#(
	parameter int MAX_TRACKS     = MAX_TRACKS_DEF,
	parameter int VOLUME_STEPS   = VOLUME_STEPS_DEF,
	parameter int DEFAULT_VOLUME = DEFAULT_VOLUME_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CNT_W-1:0]       cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// func[3:0], loop_request[4], fault_code[8:5], zero pad above
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// action[2:0], player_mode[5:3], track_index[15:6], error_status[19:16],
	// loop_active[20], volume_level[25:21], volume_gain[41:26], zero pad above
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int OUT_PAD = OUT_TDATA_W - OUT_FIELDS_W;

	logic              valid_s1;
	evt_t              evt_s1;
	logic              m_valid_q;
	action_t           action_q;
	action_t           action_d;
	logic              adv;
	logic              cfg_we;
	vol_cmd_t          vcmd;
	vol_stat_t         vstat;
	logic [MODE_W-1:0] player_mode;
	logic [TRK_W-1:0]  track_index;
	logic [ERR_W-1:0]  error_status;
	logic              loop_active;
	logic [VOLO_W-1:0] volume_level;
	logic [GAIN_W-1:0] volume_gain;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;

	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			evt_s1 <= evt_t'(s_tdata[IN_FIELDS_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_q <= action_d;
		end
	end

	mptc_ctrl #(
		.MAX_TRACKS(MAX_TRACKS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_count   (cfg_data),
		.adv         (adv),
		.evt         (evt_s1),
		.vstat       (vstat),
		.vcmd        (vcmd),
		.action_d    (action_d),
		.player_mode (player_mode),
		.track_index (track_index),
		.error_status(error_status),
		.loop_active (loop_active)
	);

	mptc_vol #(
		.VOLUME_STEPS  (VOLUME_STEPS),
		.DEFAULT_VOLUME(DEFAULT_VOLUME)
	) u_vol (
		.clk         (clk),
		.arst_n      (arst_n),
		.reinit      (cfg_we),
		.cmd         (vcmd),
		.stat        (vstat),
		.volume_level(volume_level),
		.volume_gain (volume_gain)
	);

	// state registers change only on an advance or a track count write, so they double as the result payload
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{OUT_PAD{1'b0}}, volume_gain, volume_level, loop_active,
	                   error_status, track_index, player_mode, action_q};

`ifndef SYNTHESIS
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |-> !adv)
		else $error("result overwritten while stalled");
	a_accept_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input register empty but not ready");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_valid_q)
		else $error("advanced item produced no result");
`endif

endmodule

>>> test/tb_media_player_transport_control.sv
`timescale 1ns / 1ps
// Testbench for media_player_transport_control: random and directed event items checked
// against a scoreboard class that tracks the transport state. Depends on mptc_pkg and the RTL.
module tb_media_player_transport_control;
	import mptc_pkg::*;

	localparam int N_MAX       = MAX_TRACKS_DEF;
	localparam int VOL_STEPS   = VOLUME_STEPS_DEF;
	localparam int VOL_DEFAULT = DEFAULT_VOLUME_DEF;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		action_t          act;
		logic [MODE_W-1:0] mode;
		logic [TRK_W-1:0]  track;
		logic [ERR_W-1:0]  err;
		logic              loop_on;
		logic [VOLO_W-1:0] vol;
		logic [GAIN_W-1:0] gain;
	} status_t;

	class transport_scoreboard;
		int unsigned       n_tracks;
		logic [MODE_W-1:0] mode;
		int unsigned       sel;
		logic [ERR_W-1:0]  err;
		logic              loop_on;
		int unsigned       vol;
		int unsigned       errors;
		status_t           status_q[$];

		function new();
			errors = 0;
			set_track_count('0);
		endfunction

		function void set_track_count(logic [CNT_W-1:0] v);
			n_tracks = (v > N_MAX) ? N_MAX : v;
			sel = 0;
			mode = (n_tracks == 0) ? MC_EMPTY : MC_STOPPED;
			err = '0;
			vol = VOL_DEFAULT;
			loop_on = 1'b0;
		endfunction

		function int pending();
			return status_q.size();
		endfunction

		function action_t move_track(bit fwd);
			if (n_tracks == 0)
				return ACT_NONE;
			if (fwd)
				sel = (sel + 1 >= n_tracks) ? 0 : sel + 1;
			else if (sel == 0 || sel >= n_tracks)
				sel = n_tracks - 1;
			else
				sel--;
			mode = MC_LOADING;
			err = '0;
			loop_on = 1'b0;
			return ACT_LOAD;
		endfunction

		function action_t begin_play();
			if (n_tracks == 0 || (mode != MC_STOPPED && mode != MC_ERROR))
				return ACT_NONE;
			mode = MC_LOADING;
			err = '0;
			loop_on = 1'b0;
			return ACT_LOAD;
		endfunction

		function void note_event(evt_t e);
			status_t     r;
			action_t     act;
			int unsigned lvl;
			act = ACT_NONE;
			case (e.func)
				FN_BEGIN: act = begin_play();
				FN_LOADED: if (mode == MC_LOADING) begin
					mode = MC_PREFILLING;
					loop_on = e.loop_request;
				end
				FN_PREFILLED: if (mode == MC_PREFILLING) begin
					mode = MC_PLAYING;
					act = ACT_START;
				end
				FN_PREV: act = move_track(1'b0);
				FN_NEXT: act = move_track(1'b1);
				FN_PLAY_PAUSE: if (mode == MC_PLAYING) begin
					mode = MC_PAUSED;
					act = ACT_PAUSE;
				end else if (mode == MC_PAUSED) begin
					mode = MC_PLAYING;
					act = ACT_RESUME;
				end else begin
					act = begin_play();
				end
				FN_VOL_DOWN: if (vol != 0) begin
					vol--;
					act = ACT_VOLUME;
				end
				FN_VOL_UP: if (vol < VOL_STEPS) begin
					vol++;
					act = ACT_VOLUME;
				end
				FN_NATURAL_END: if (mode == MC_PLAYING && !loop_on && n_tracks != 0) begin
					act = move_track(1'b1);
				end
				FN_FAIL: if (e.fault_code != 0) begin
					mode = MC_ERROR;
					err = e.fault_code;
					loop_on = 1'b0;
					act = ACT_STOP;
				end
				default: ;
			endcase
			lvl = (vol > VOL_STEPS) ? VOL_STEPS : vol;
			r.act = act;
			r.mode = mode;
			r.track = sel[TRK_W-1:0];
			r.err = err;
			r.loop_on = loop_on;
			r.vol = vol[VOLO_W-1:0];
			r.gain = GAIN_W'(lvl * GAIN_ONE / VOL_STEPS);
			status_q.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned e, int unsigned a);
			if (e != a) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] d);
			status_t r;
			if (status_q.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, got %h", $time, d);
				errors++;
				return;
			end
			r = status_q.pop_front();
			compare_field("action", r.act, d[2:0]);
			compare_field("player_mode", r.mode, d[5:3]);
			compare_field("track_index", r.track, d[15:6]);
			compare_field("error_status", r.err, d[19:16]);
			compare_field("loop_active", r.loop_on, d[20]);
			compare_field("volume_level", r.vol, d[25:21]);
			compare_field("volume_gain", r.gain, d[41:26]);
			compare_field("pad", 0, d[OUT_TDATA_W-1:OUT_FIELDS_W]);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CNT_W-1:0]       cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	transport_scoreboard sb;
	bit quiet = 1'b0;
	bit hold_request = 1'b0;
	int stall_cycles = 0;

	always #2 clk = ~clk;

	media_player_transport_control #(
		.MAX_TRACKS(N_MAX),
		.VOLUME_STEPS(VOL_STEPS),
		.DEFAULT_VOLUME(VOL_DEFAULT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// result side: check, then pick next ready; a requested hold-off runs here
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(99) >= 26);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("media_player_transport_control test failed");
			$finish;
		end
	end

	function automatic evt_t ev(logic [FUNC_W-1:0] f, logic lp, logic [FAULT_W-1:0] fc);
		evt_t e;
		e.func = f;
		e.loop_request = lp;
		e.fault_code = fc;
		return e;
	endfunction

	// mostly the event that moves the player along from its current mode
	function automatic evt_t pick_event();
		evt_t e;
		e = ev(FUNC_W'($urandom_range(15)), 1'($urandom_range(1)),
			FAULT_W'($urandom_range(15)));
		if ($urandom_range(99) < 35)
			return e;
		case (sb.mode)
			MC_LOADING: e.func = FN_LOADED;
			MC_PREFILLING: e.func = FN_PREFILLED;
			MC_PLAYING: case ($urandom_range(9)) inside
				0, 1, 2, 3: e.func = FN_NATURAL_END;
				4, 5: e.func = FN_PLAY_PAUSE;
				6: e.func = FN_NEXT;
				7: e.func = FN_PREV;
				8: e.func = FN_FAIL;
				default: e.func = FN_VOL_DOWN;
			endcase
			MC_PAUSED: case ($urandom_range(3)) inside
				0, 1: e.func = FN_PLAY_PAUSE;
				2: e.func = FN_VOL_UP;
				default: e.func = FN_PREV;
			endcase
			default: case ($urandom_range(4)) inside
				0, 1: e.func = FN_BEGIN;
				2, 3: e.func = FN_PLAY_PAUSE;
				default: e.func = FN_NEXT;
			endcase
		endcase
		return e;
	endfunction

	task automatic send_event(evt_t e);
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'(e);
		do @(posedge clk); while (!(s_tvalid && s_tready));
		sb.note_event(e);
		if (!quiet && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
	endtask

	task automatic write_track_count(logic [CNT_W-1:0] v);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_track_count(v);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int n);
		int i;
		int len;
		bit up;
		i = 0;
		while (i < n) begin
			// volume sweeps reach both bounds
			if ($urandom_range(99) < 4) begin
				up = 1'($urandom_range(1));
				len = $urandom_range(4, 18);
				repeat (len) send_event(ev(up ? FN_VOL_UP : FN_VOL_DOWN,
					1'($urandom_range(1)), FAULT_W'($urandom_range(15))));
				i += len;
			end else begin
				send_event(pick_event());
				i++;
			end
		end
	endtask

	initial begin
		logic [CNT_W-1:0] counts[9];
		sb = new();
		counts = '{11'd1, 11'd2047, 11'd1024, 11'd0, 11'd2, 11'd7,
			CNT_W'($urandom_range(2047)), 11'd1024, CNT_W'($urandom_range(2047))};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no tracks after reset: transport events do nothing, a fault still counts
		send_event(ev(FN_BEGIN, 1'b0, 4'd0));
		send_event(ev(FN_NEXT, 1'b1, 4'd0));
		send_event(ev(FN_PLAY_PAUSE, 1'b0, 4'd0));
		send_event(ev(FN_NATURAL_END, 1'b0, 4'd0));
		send_event(ev(FN_FAIL, 1'b1, 4'd0));
		send_event(ev(FN_FAIL, 1'b0, 4'd15));
		send_event(ev(FN_BEGIN, 1'b0, 4'd0));

		write_track_count(11'd3);
		send_event(ev(FN_BEGIN, 1'b0, 4'd0));
		send_event(ev(FN_LOADED, 1'b1, 4'd0));
		send_event(ev(FN_PREFILLED, 1'b0, 4'd0));
		send_event(ev(FN_NATURAL_END, 1'b0, 4'd0));  // looping: ignored
		send_event(ev(FN_PLAY_PAUSE, 1'b0, 4'd0));
		send_event(ev(FN_PLAY_PAUSE, 1'b0, 4'd0));
		send_event(ev(FN_PREV, 1'b0, 4'd0));         // wraps to last track
		send_event(ev(FN_LOADED, 1'b0, 4'd0));
		send_event(ev(FN_PREFILLED, 1'b0, 4'd0));
		send_event(ev(FN_NATURAL_END, 1'b0, 4'd0));  // wraps to track 0
		send_event(ev(FN_FAIL, 1'b0, 4'd9));
		send_event(ev(FN_BEGIN, 1'b0, 4'd0));
		send_event(ev(4'd15, 1'b1, 4'd15));
		send_event(ev(4'd10, 1'b0, 4'd0));
		send_event(ev(FN_VOL_UP, 1'b0, 4'd0));
		send_event(ev(FN_VOL_DOWN, 1'b0, 4'd0));

		for (int p = 0; p < 9; p++) begin
			write_track_count(counts[p]);
			if (p == 2)
				hold_request = 1'b1;
			quiet = (p == 5);
			run_random(140);
		end
		quiet = 1'b0;

		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("media_player_transport_control test passed");
		else
			$display("media_player_transport_control test failed");
		$finish;
	end

endmodule
